/* rtl/core/multi_channel_heartbeat_watchdog_macros.svh */
// Assertion macros shared by the watchdog checker.
// Expects clk and rst_n in the scope of each use.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_MACROS_SVH

// Consequent must hold in the same cycle.
`define MCHW_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the following cycle.
`define MCHW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mchw_pkg.sv */
// Shared types and constants of the heartbeat watchdog.
// No dependencies.
`timescale 1ns / 1ps

package mchw_pkg;

    localparam int FUNC_W     = 3;
    localparam int WIDX_W     = 8;
    localparam int TIME_W     = 32;
    localparam int SINCE_W    = 17;
    localparam int ELAPSED_W  = 16;
    localparam int HUNG_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BEAT     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ARM      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DISARM   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESTARTS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD = 2'd3;

    localparam logic [15:0] TIMEOUT_RST      = 16'd10;
    localparam logic [15:0] COOLDOWN_RST     = 16'd60;
    localparam logic [7:0]  MAX_RESTARTS_RST = 8'd3;
    localparam logic [7:0]  CHECK_PERIOD_RST = 8'd2;

    localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

    typedef struct packed {
        logic accept;
        logic exec;
        logic read;
        logic capture;
        logic next;
        logic raise;
        logic load;
    } mchw_cmd_t;

    typedef struct packed {
        logic scan_due;
        logic count_zero;
        logic hit;
        logic last;
        logic out_free;
    } mchw_status_t;

endpackage

/* rtl/core/multi_channel_heartbeat_watchdog.sv */
// Top level of the heartbeat watchdog: sequencer plus datapath.
// Depends on mchw_pkg, mchw_ctrl, mchw_dp.
//
//   group   direction  handshake           payload
//   s_*     in         s_tvalid/s_tready   tuser func, tdata worker_index
//   m_*     out        m_tvalid/m_tready   tdata result fields
//   cfg_*   in         cfg_we              cfg_index, cfg_data
//
// An event without a scan goes from accept through execute to the result register.
// A scanning tick adds one stamp RAM read and one compare per worker checked, and
// a raise step when a restart is raised; the scan stops at the first hung worker.
// The result register frees the next request while a result waits.
// Reset loads the config defaults and clears the control state; stamps read as zero until written.
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog
    import mchw_pkg::*;
#(
    parameter int WORKER_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] worker_index
    input  logic [FUNC_W-1:0]     s_tuser,   // [2:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] restart_now, [4:1] hung_worker, [20:5] hung_elapsed,
    // [21] restart_requested, [22] throttled, [23] monitoring
    output logic [M_TDATA_W-1:0]  m_tdata
);

    mchw_cmd_t    cmd;
    mchw_status_t status;

    mchw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mchw_dp #(
        .WORKER_SLOTS (WORKER_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/core/mchw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mchw_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/mchw_ctrl.sv */
// Sequencer of the heartbeat watchdog: accept, execute, scan, raise, deliver.
// Depends on mchw_pkg.
`timescale 1ns / 1ps

module mchw_ctrl
    import mchw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  mchw_status_t status,
    output mchw_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_RAISE = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.scan_due && !status.count_zero)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (status.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RAISE;
                end
                else if (status.last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_RAISE:
            begin
                cmd.raise  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/mchw_dp.sv */
// Datapath of the heartbeat watchdog: clock, stamps, restart throttle, result register.
// Depends on mchw_pkg and mchw_ram.
`timescale 1ns / 1ps

module mchw_dp
    import mchw_pkg::*;
#(
    parameter int WORKER_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  mchw_cmd_t             cmd,
    output mchw_status_t          status
);

    localparam int IDX_W = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
    localparam int CNT_W = $clog2(WORKER_SLOTS + 1);

    logic [15:0]            timeout_reg, timeout_next;
    logic [15:0]            cooldown_reg, cooldown_next;
    logic [7:0]             max_reg, max_next;
    logic [7:0]             period_reg, period_next;
    logic [TIME_W-1:0]      clock_reg, clock_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [7:0]             phase_reg, phase_next;
    logic                   armed_reg, armed_next;
    logic [7:0]             rapid_reg, rapid_next;
    logic [SINCE_W-1:0]     since_reg, since_next;
    logic [15:0]            hold_reg, hold_next;
    logic                   req_reg, req_next;
    logic [HUNG_W-1:0]      pworker_reg, pworker_next;
    logic [ELAPSED_W-1:0]   pelapsed_reg, pelapsed_next;
    logic                   fire_reg, fire_next;
    logic [WORKER_SLOTS-1:0] valid_reg, valid_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [WIDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;

    logic [7:0]        phase_inc;
    logic [7:0]        rapid_inc;
    logic [7:0]        scan_ext;
    logic              tick;
    logic              in_range;
    logic              scan_due;
    logic              ram_we;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] beat_val;
    logic [TIME_W-1:0] quiet;
    logic              hit;

    mchw_ram #(
        .WIDTH  (TIME_W),
        .DEPTH  (WORKER_SLOTS),
        .ADDR_W (IDX_W)
    ) u_beat_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (clock_reg),
        .re    (cmd.read),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign tick      = (func_reg == FUNC_TICK);
    assign in_range  = ({1'b0, idx_reg} < 9'(WORKER_SLOTS));
    assign phase_inc = (phase_reg != 8'hFF) ? phase_reg + 8'd1 : phase_reg;
    assign rapid_inc = (rapid_reg != 8'hFF) ? rapid_reg + 8'd1 : rapid_reg;
    assign scan_due  = tick && (hold_reg == 16'd0) && armed_reg && (phase_inc >= period_reg);
    assign ram_we    = cmd.exec && in_range
                       && ((func_reg == FUNC_REGISTER) || (func_reg == FUNC_BEAT));
    assign beat_val  = rd_valid_reg ? ram_rdata : '0;
    assign quiet     = clock_reg - beat_val;
    assign hit       = (quiet > {16'd0, timeout_reg});
    assign scan_ext  = 8'(scan_reg);

    assign status.scan_due   = scan_due;
    assign status.count_zero = (count_reg == '0);
    assign status.hit        = hit;
    assign status.last       = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        timeout_next   = timeout_reg;
        cooldown_next  = cooldown_reg;
        max_next       = max_reg;
        period_next    = period_reg;
        clock_next     = clock_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        armed_next     = armed_reg;
        rapid_next     = rapid_reg;
        since_next     = since_reg;
        hold_next      = hold_reg;
        req_next       = req_reg;
        pworker_next   = pworker_reg;
        pelapsed_next  = pelapsed_reg;
        fire_next      = fire_reg;
        valid_next     = valid_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:      timeout_next  = cfg_data;
                CFG_COOLDOWN:     cooldown_next = cfg_data;
                CFG_MAX_RESTARTS: max_next      = cfg_data[7:0];
                CFG_CHECK_PERIOD: period_next   = cfg_data[7:0];
                default:          timeout_next  = timeout_reg;
            endcase
        end

        if (cmd.accept)
        begin
            func_next = s_tuser;
            idx_next  = s_tdata[WIDX_W-1:0];
        end

        if (cmd.exec)
        begin
            fire_next = 1'b0;
            unique case (func_reg)
                FUNC_TICK:
                begin
                    clock_next = clock_reg + 32'd1;
                    if (since_reg != SINCE_MAX)
                    begin
                        since_next = since_reg + 17'd1;
                    end
                    if (hold_reg != 16'd0)
                    begin
                        hold_next = hold_reg - 16'd1;
                        fire_next = (hold_reg == 16'd1);
                    end
                    else if (armed_reg)
                    begin
                        phase_next = scan_due ? 8'd0 : phase_inc;
                        scan_next  = '0;
                    end
                end
                FUNC_REGISTER:
                begin
                    if (in_range)
                    begin
                        valid_next[idx_reg[IDX_W-1:0]] = 1'b1;
                        if (count_reg < CNT_W'(WORKER_SLOTS))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                FUNC_BEAT:
                begin
                    if (in_range)
                    begin
                        valid_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    end
                end
                FUNC_ARM:
                begin
                    armed_next = 1'b1;
                    phase_next = 8'd0;
                end
                FUNC_DISARM:
                begin
                    armed_next = 1'b0;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end

        if (cmd.read)
        begin
            rd_valid_next = valid_reg[scan_reg];
        end

        if (cmd.next)
        begin
            scan_next = scan_reg + IDX_W'(1);
        end

        if (cmd.capture)
        begin
            pworker_next  = scan_ext[HUNG_W-1:0];
            pelapsed_next = (quiet[31:16] != 16'd0) ? 16'hFFFF : quiet[15:0];
            armed_next    = 1'b0;
        end

        if (cmd.raise)
        begin
            since_next = '0;
            fire_next  = 1'b1;
            if ({1'b0, since_reg} < {2'b0, cooldown_reg})
            begin
                if (rapid_inc >= max_reg)
                begin
                    rapid_next = 8'd0;
                    hold_next  = cooldown_reg;
                    fire_next  = (cooldown_reg == 16'd0);
                end
                else
                begin
                    rapid_next = rapid_inc;
                end
            end
            else
            begin
                rapid_next = 8'd1;
            end
        end

        if ((cmd.exec || cmd.raise) && fire_next)
        begin
            req_next = 1'b1;
        end

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {armed_reg, (hold_reg != 16'd0), req_reg,
                              pelapsed_reg, pworker_reg, fire_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            cooldown_reg  <= COOLDOWN_RST;
            max_reg       <= MAX_RESTARTS_RST;
            period_reg    <= CHECK_PERIOD_RST;
            clock_reg     <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            armed_reg     <= 1'b0;
            rapid_reg     <= '0;
            since_reg     <= SINCE_MAX;
            hold_reg      <= '0;
            req_reg       <= 1'b0;
            pworker_reg   <= '0;
            pelapsed_reg  <= '0;
            fire_reg      <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            cooldown_reg  <= cooldown_next;
            max_reg       <= max_next;
            period_reg    <= period_next;
            clock_reg     <= clock_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            armed_reg     <= armed_next;
            rapid_reg     <= rapid_next;
            since_reg     <= since_next;
            hold_reg      <= hold_next;
            req_reg       <= req_next;
            pworker_reg   <= pworker_next;
            pelapsed_reg  <= pelapsed_next;
            fire_reg      <= fire_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
    end

endmodule

/* rtl/core/mchw_checker.sv */
// Port-level checks of the heartbeat watchdog, bound to the top level.
// Depends on mchw_pkg and the watchdog macro header.
`timescale 1ns / 1ps
`include "multi_channel_heartbeat_watchdog_macros.svh"

module mchw_checker
    import mchw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    `MCHW_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `MCHW_CHECK_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `MCHW_CHECK_SAME(a_fire_sticky, m_tvalid && m_tdata[0], m_tdata[21], "restart without sticky flag")
    `MCHW_CHECK_SAME(a_fire_not_held, m_tvalid && m_tdata[0], !m_tdata[22], "restart issued while held")

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_checker (.*);

/* bench/mchw_result_checker.sv */
// Result checker for the heartbeat watchdog: mirrors config writes, predicts each result.
// Compares every accepted result field by field in request order.
// Depends on mchw_pkg.
`timescale 1ns / 1ps

module mchw_result_checker
    import mchw_pkg::*;
#(
    parameter int WORKER_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    fail_count,
    output int                    results_due
);

    typedef struct packed {
        logic                 monitoring;
        logic                 throttled;
        logic                 requested;
        logic [ELAPSED_W-1:0] elapsed;
        logic [HUNG_W-1:0]    worker;
        logic                 restart;
    } wd_result_t;

    logic [15:0]          timeout_cfg;
    logic [15:0]          cooldown_cfg;
    logic [7:0]           rapid_limit_cfg;
    logic [7:0]           period_cfg;

    logic [TIME_W-1:0]    seconds;
    logic [TIME_W-1:0]    stamp [WORKER_SLOTS];
    int unsigned          registered;
    logic [7:0]           phase;
    logic                 armed;
    logic [7:0]           rapid;
    logic [SINCE_W-1:0]   since;
    logic [15:0]          hold;
    logic                 requested;
    logic [HUNG_W-1:0]    hung_idx;
    logic [ELAPSED_W-1:0] hung_quiet;

    wd_result_t           expected_results [$];
    int                   failures;

    function automatic wd_result_t advance_watchdog(input logic [FUNC_W-1:0] func,
                                                    input logic [WIDX_W-1:0] widx);
        logic              fire;
        logic              found;
        logic [TIME_W-1:0] quiet;
        wd_result_t        r;
        fire = 1'b0;
        found = 1'b0;
        case (func)
            FUNC_TICK:
            begin
                seconds = seconds + 32'd1;
                if (since != SINCE_MAX)
                    since = since + 17'd1;
                if (hold != 16'd0)
                begin
                    hold = hold - 16'd1;
                    fire = (hold == 16'd0);
                end
                else if (armed)
                begin
                    if (phase != 8'hFF)
                        phase = phase + 8'd1;
                    if (phase >= period_cfg)
                    begin
                        phase = '0;
                        for (int i = 0; i < WORKER_SLOTS; i++)
                        begin
                            quiet = seconds - stamp[i];
                            if (!found && i < registered && quiet > 32'(timeout_cfg))
                            begin
                                found = 1'b1;
                                hung_idx = HUNG_W'(i);
                                hung_quiet = (quiet > 32'd65535) ? 16'hFFFF : quiet[15:0];
                                armed = 1'b0;
                                if (since < 17'(cooldown_cfg))
                                begin
                                    if (rapid != 8'hFF)
                                        rapid = rapid + 8'd1;
                                    if (rapid >= rapid_limit_cfg)
                                    begin
                                        rapid = '0;
                                        hold = cooldown_cfg;
                                    end
                                end
                                else
                                    rapid = 8'd1;
                                since = '0;
                                fire = (hold == 16'd0);
                            end
                        end
                    end
                end
            end
            FUNC_REGISTER:
            begin
                if (widx < WORKER_SLOTS)
                begin
                    stamp[widx] = seconds;
                    if (registered < WORKER_SLOTS)
                        registered++;
                end
            end
            FUNC_BEAT:
            begin
                if (widx < WORKER_SLOTS)
                    stamp[widx] = seconds;
            end
            FUNC_ARM:
            begin
                armed = 1'b1;
                phase = '0;
            end
            FUNC_DISARM:
                armed = 1'b0;
            default:
                ;
        endcase
        if (fire)
            requested = 1'b1;
        r.restart    = fire;
        r.worker     = hung_idx;
        r.elapsed    = hung_quiet;
        r.requested  = requested;
        r.throttled  = (hold != 16'd0);
        r.monitoring = armed;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wd_result_t got;
        wd_result_t want;
        if (!rst_n)
        begin
            timeout_cfg = TIMEOUT_RST;
            cooldown_cfg = COOLDOWN_RST;
            rapid_limit_cfg = MAX_RESTARTS_RST;
            period_cfg = CHECK_PERIOD_RST;
            seconds = '0;
            for (int i = 0; i < WORKER_SLOTS; i++)
                stamp[i] = '0;
            registered = 0;
            phase = '0;
            armed = 1'b0;
            rapid = '0;
            since = SINCE_MAX;
            hold = '0;
            requested = 1'b0;
            hung_idx = '0;
            hung_quiet = '0;
            expected_results.delete();
            failures = 0;
            fail_count <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEOUT:      timeout_cfg = cfg_data;
                    CFG_COOLDOWN:     cooldown_cfg = cfg_data;
                    CFG_MAX_RESTARTS: rapid_limit_cfg = cfg_data[7:0];
                    CFG_CHECK_PERIOD: period_cfg = cfg_data[7:0];
                    default:          ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: result expected none actual %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("restart_now", want.restart, got.restart);
                    check_field("hung_worker", want.worker, got.worker);
                    check_field("hung_elapsed", want.elapsed, got.elapsed);
                    check_field("restart_requested", want.requested, got.requested);
                    check_field("throttled", want.throttled, got.throttled);
                    check_field("monitoring", want.monitoring, got.monitoring);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        advance_watchdog(s_tuser, s_tdata));
            fail_count <= failures;
            results_due <= expected_results.size();
        end
    end

endmodule

/* bench/multi_channel_heartbeat_watchdog_tb.sv */
// Testbench top of the heartbeat watchdog: clock, reset, config phases and event stimulus.
// Depends on mchw_pkg, multi_channel_heartbeat_watchdog and mchw_result_checker.
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_tb;
    import mchw_pkg::*;

    localparam int SLOTS          = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 60;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  steady;
    int                    fail_count;
    int                    results_due;
    int                    stall_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    multi_channel_heartbeat_watchdog #(
        .WORKER_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mchw_result_checker #(
        .WORKER_SLOTS(SLOTS)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .results_due(results_due)
    );

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [WIDX_W-1:0] w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] t, input logic [15:0] c,
                              input logic [7:0] m, input logic [7:0] p);
        cfg_write(CFG_TIMEOUT, t);
        cfg_write(CFG_COOLDOWN, c);
        cfg_write(CFG_MAX_RESTARTS, {8'($urandom), m});
        cfg_write(CFG_CHECK_PERIOD, {8'($urandom), p});
    endtask

    // Drain results, with random stalls outside steady phases.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                pick;
        logic [FUNC_W-1:0] f;
        logic [WIDX_W-1:0] w;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_TICK;
        steady = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every operation, index extremes, ignored indices and spare codes.
        send_req(FUNC_REGISTER, 8'd0);
        send_req(FUNC_REGISTER, 8'd15);
        send_req(FUNC_REGISTER, 8'd16);
        send_req(FUNC_BEAT, 8'd255);
        send_req(FUNC_BEAT, 8'd15);
        send_req(FUNC_SPARE_A, 8'hAA);
        send_req(FUNC_SPARE_B, 8'h55);
        send_req(FUNC_SPARE_C, 8'hFF);
        send_req(FUNC_ARM, 8'd0);
        send_req(FUNC_ARM, 8'd0);
        send_req(FUNC_TICK, 8'd0);
        send_req(FUNC_TICK, 8'd0);
        send_req(FUNC_DISARM, 8'd0);
        send_req(FUNC_TICK, 8'd0);

        // Zero timeout, cooldown, limit and period: restart on every armed tick.
        settle();
        set_config(16'd0, 16'd0, 8'd0, 8'd0);
        send_req(FUNC_ARM, 8'd0);
        send_req(FUNC_TICK, 8'd0);
        send_req(FUNC_ARM, 8'd0);
        send_req(FUNC_TICK, 8'd0);

        // Rapid restart with zero limit: hold, arm during the hold, release.
        settle();
        set_config(16'd0, 16'd4, 8'd0, 8'd1);
        send_req(FUNC_ARM, 8'd0);
        send_req(FUNC_TICK, 8'd0);
        send_req(FUNC_ARM, 8'd0);
        repeat (4) send_req(FUNC_TICK, 8'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                1: set_config(16'd0, 16'd0, 8'd1, 8'd1);
                default:
                    set_config(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 12)),
                               ($urandom_range(0, 9) == 0) ? 16'd0
                                                           : 16'($urandom_range(1, 30)),
                               ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(1, 4)),
                               ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(1, 4)));
            endcase
            steady <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                w = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOTS - 1));
                if (pick < 45)
                    f = FUNC_TICK;
                else if (pick < 70)
                    f = FUNC_BEAT;
                else if (pick < 78)
                    f = FUNC_REGISTER;
                else if (pick < 90)
                    f = FUNC_ARM;
                else if (pick < 96)
                    f = FUNC_DISARM;
                else
                    f = FUNC_W'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
                send_req(f, w);
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mchw_pkg.sv
rtl/core/mchw_ram.sv
rtl/core/mchw_ctrl.sv
rtl/core/mchw_dp.sv
rtl/core/multi_channel_heartbeat_watchdog.sv
rtl/core/mchw_checker.sv
bench/mchw_result_checker.sv
bench/multi_channel_heartbeat_watchdog_tb.sv
